[rtl/midi_track_event_parser_assert.svh]
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Concurrent assertion with an explicit clock and active-low reset.
`define MTEP_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MTEP_ASSERT(lbl, prop, msg) `MTEP_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[rtl/mtep_pkg.sv]
package mtep_pkg;

	// Field widths
	localparam int LEN_W = 28;
	localparam int MAX_LENGTH_BYTES = 4;
	localparam int LEN_CNT_W = 3;
	localparam logic [LEN_CNT_W-1:0] MAX_CNT = LEN_CNT_W'(MAX_LENGTH_BYTES);

	// Byte queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Result kinds
	localparam logic [2:0] KIND_CHANNEL = 3'd0;
	localparam logic [2:0] KIND_SYSEX = 3'd1;
	localparam logic [2:0] KIND_META = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_TOO_LONG = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN_STATUS = 2'd1;
	localparam logic [1:0] ERR_EARLY_END = 2'd2;

	// Special status and meta codes
	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
	localparam logic [7:0] STATUS_META = 8'hFF;
	localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_PARAM1,
		PH_PARAM2,
		PH_SYSLEN,
		PH_METATYPE,
		PH_METALEN,
		PH_PAYLOAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		SC_CHANNEL,
		SC_SYSEX,
		SC_META,
		SC_UNKNOWN
	} sclass_t;

	// One classified byte transaction
	typedef struct packed {
		logic [7:0] data;
		logic track_start;
		logic data_end;
		logic is_data;
		sclass_t sclass;
	} qent_t;

	// One result transaction
	typedef struct packed {
		logic [2:0] kind;
		logic [LEN_W-1:0] delta_ticks;
		logic [7:0] status_byte;
		logic [3:0] channel;
		logic [7:0] first_value;
		logic [7:0] second_value;
		logic [LEN_W-1:0] payload_length;
		logic last;
		logic end_of_track;
		logic [1:0] error_code;
	} result_t;

	// Class of a byte taken as a status byte
	function automatic sclass_t status_class(input logic [7:0] st);
		sclass_t c;
		if (st[7] && st[7:4] != 4'hF)
			c = SC_CHANNEL;
		else if (st == STATUS_SYSEX || st == STATUS_ESCAPE)
			c = SC_SYSEX;
		else if (st == STATUS_META)
			c = SC_META;
		else
			c = SC_UNKNOWN;
		return c;
	endfunction

	// Note off/on, poly pressure, controller and pitch bend carry two parameters
	function automatic logic two_params(input logic [7:0] st);
		logic r;
		case (st[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Shift seven more bits into a variable-length quantity
	function automatic logic [LEN_W-1:0] vlq_shift(input logic [LEN_W-1:0] acc,
			input logic [7:0] b);
		return {acc[LEN_W-8:0], b[6:0]};
	endfunction

endpackage

[rtl/mtep_front.sv]
module mtep_front (
	input  logic byte_valid,
	output logic byte_ready,
	input  logic [7:0] data_byte,
	input  logic track_start,
	input  logic data_end,
	output logic push,
	output mtep_pkg::qent_t push_ent,
	input  logic queue_ready
);
	import mtep_pkg::*;

	// Accept whenever the queue has room
	assign byte_ready = queue_ready;
	assign push = byte_valid & queue_ready;

	// Classify the byte once, before it enters the queue
	always_comb begin
		push_ent.data = data_byte;
		push_ent.track_start = track_start;
		push_ent.data_end = data_end;
		push_ent.is_data = ~data_byte[7];
		push_ent.sclass = status_class(data_byte);
	end

endmodule

[rtl/mtep_queue.sv]
module mtep_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mtep_pkg::qent_t push_ent,
	output logic push_ready,
	output logic pop_valid,
	output mtep_pkg::qent_t pop_ent,
	input  logic pop
);
	import mtep_pkg::*;

	qent_t ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_ent = ent_q[rd_ptr_q];
	assign do_push = push & push_ready;
	assign do_pop = pop & pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_ent;
	end

endmodule

[rtl/mtep_back.sv]
module mtep_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  mtep_pkg::qent_t q_ent,
	output logic q_pop,
	output logic res_valid,
	input  logic res_ready,
	output mtep_pkg::result_t res
);
	import mtep_pkg::*;

	phase_t phase_q, phase_d, ph_e;
	logic [7:0] rs_q, rs_d, rs_e;
	logic [7:0] cs_q, cs_d, cs_e;
	logic [LEN_W-1:0] acc_q, acc_d, acc_e;
	logic [LEN_CNT_W-1:0] cnt_q, cnt_d, cnt_e;
	logic [LEN_W-1:0] hd_q, hd_d, hd_e;
	logic [7:0] hp_q, hp_d, hp_e;
	logic [7:0] hmt_q, hmt_d, hmt_e;
	logic [LEN_W-1:0] br_q, br_d, br_e;
	logic res_valid_q;
	result_t res_q, res_d;
	logic res_v;
	logic advance;
	logic ts;
	logic [7:0] b;

	// Consume one queued byte whenever the output register is free or draining
	assign advance = q_valid & (~res_valid_q | res_ready);
	assign q_pop = advance;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Track start clears the parser before the byte is used
	assign ts = q_ent.track_start;
	assign b = q_ent.data;
	assign ph_e = ts ? PH_DELTA : phase_q;
	assign rs_e = ts ? '0 : rs_q;
	assign cs_e = ts ? '0 : cs_q;
	assign acc_e = ts ? '0 : acc_q;
	assign cnt_e = ts ? '0 : cnt_q;
	assign hd_e = ts ? '0 : hd_q;
	assign hp_e = ts ? '0 : hp_q;
	assign hmt_e = ts ? '0 : hmt_q;
	assign br_e = ts ? '0 : br_q;

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			rs_q <= '0;
			cs_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			hd_q <= '0;
			hp_q <= '0;
			hmt_q <= '0;
			br_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			rs_q <= rs_d;
			cs_q <= cs_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			hd_q <= hd_d;
			hp_q <= hp_d;
			hmt_q <= hmt_d;
			br_q <= br_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= res_v;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_v)
			res_q <= res_d;
	end

	// Next state and result for one byte
	always_comb begin
		phase_t bph;
		logic [7:0] bcs;
		logic [LEN_W-1:0] bacc;
		logic [LEN_CNT_W-1:0] bcnt;
		logic do_body;
		logic [7:0] st;
		sclass_t st_cls;
		logic [LEN_W-1:0] vacc;
		logic [LEN_CNT_W-1:0] vcnt;
		logic blk_emit;
		logic final_blk;
		logic meta;

		phase_d = ph_e;
		rs_d = rs_e;
		cs_d = cs_e;
		acc_d = acc_e;
		cnt_d = cnt_e;
		hd_d = hd_e;
		hp_d = hp_e;
		hmt_d = hmt_e;
		br_d = br_e;
		bph = ph_e;
		bcs = cs_e;
		bacc = acc_e;
		bcnt = cnt_e;
		do_body = 1'b0;
		st = b;
		st_cls = q_ent.sclass;
		vacc = '0;
		vcnt = '0;
		blk_emit = 1'b0;
		final_blk = 1'b0;
		meta = 1'b0;
		res_d = '0;
		res_v = 1'b0;

		if (q_ent.data_end) begin
			// End of data before the track finished
			if (ph_e != PH_DONE && ph_e != PH_ERROR) begin
				if (ph_e == PH_DELTA && cnt_e != '0)
					hd_d = '0;
				phase_d = PH_ERROR;
				res_v = 1'b1;
				res_d.kind = KIND_ERROR;
				res_d.status_byte = cs_e;
				res_d.delta_ticks = hd_d;
				res_d.last = 1'b1;
				res_d.error_code = ERR_EARLY_END;
			end
		end else begin
			case (ph_e)
				PH_DELTA: begin
					if (cnt_e == '0) begin
						hd_d = '0;
						cs_d = '0;
						hmt_d = '0;
					end
					vacc = vlq_shift(acc_e, b);
					vcnt = cnt_e + 1'b1;
					acc_d = vacc;
					cnt_d = vcnt;
					if (!b[7]) begin
						hd_d = vacc;
						phase_d = PH_STATUS;
					end else if (vcnt >= MAX_CNT) begin
						phase_d = PH_ERROR;
						res_v = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.status_byte = cs_d;
						res_d.delta_ticks = hd_d;
						res_d.last = 1'b1;
						res_d.error_code = ERR_TOO_LONG;
					end
				end
				PH_STATUS: begin
					// Running status: a data byte reuses the last status
					if (q_ent.is_data) begin
						st = rs_e;
						st_cls = status_class(rs_e);
					end else begin
						rs_d = b;
					end
					cs_d = st;
					bcs = st;
					case (st_cls)
						SC_CHANNEL: bph = PH_PARAM1;
						SC_SYSEX: begin
							bph = PH_SYSLEN;
							bacc = '0;
							bcnt = '0;
						end
						SC_META: bph = PH_METATYPE;
						default: bph = PH_ERROR;
					endcase
					if (st_cls == SC_UNKNOWN) begin
						phase_d = PH_ERROR;
						res_v = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.status_byte = st;
						res_d.delta_ticks = hd_e;
						res_d.last = 1'b1;
						res_d.error_code = ERR_UNKNOWN_STATUS;
					end else begin
						phase_d = bph;
						acc_d = bacc;
						cnt_d = bcnt;
						do_body = q_ent.is_data;
					end
				end
				PH_DONE, PH_ERROR: begin
				end
				default: do_body = 1'b1;
			endcase

			// Bytes after the status
			if (do_body) begin
				case (bph)
					PH_PARAM1: begin
						hp_d = b;
						if (two_params(bcs)) begin
							phase_d = PH_PARAM2;
						end else begin
							phase_d = PH_DELTA;
							acc_d = '0;
							cnt_d = '0;
							res_v = 1'b1;
							res_d.kind = KIND_CHANNEL;
							res_d.delta_ticks = hd_e;
							res_d.status_byte = {bcs[7:4], 4'h0};
							res_d.channel = bcs[3:0];
							res_d.first_value = b;
							res_d.last = 1'b1;
						end
					end
					PH_PARAM2: begin
						phase_d = PH_DELTA;
						acc_d = '0;
						cnt_d = '0;
						res_v = 1'b1;
						res_d.kind = KIND_CHANNEL;
						res_d.delta_ticks = hd_e;
						res_d.status_byte = {bcs[7:4], 4'h0};
						res_d.channel = bcs[3:0];
						res_d.first_value = hp_e;
						res_d.second_value = b;
						res_d.last = 1'b1;
					end
					PH_METATYPE: begin
						hmt_d = b;
						phase_d = PH_METALEN;
						acc_d = '0;
						cnt_d = '0;
					end
					PH_SYSLEN, PH_METALEN: begin
						vacc = vlq_shift(bacc, b);
						vcnt = bcnt + 1'b1;
						acc_d = vacc;
						cnt_d = vcnt;
						if (b[7]) begin
							if (vcnt >= MAX_CNT) begin
								phase_d = PH_ERROR;
								res_v = 1'b1;
								res_d.kind = KIND_ERROR;
								res_d.status_byte = bcs;
								res_d.delta_ticks = hd_e;
								res_d.last = 1'b1;
								res_d.error_code = ERR_TOO_LONG;
							end
						end else begin
							br_d = vacc;
							meta = (bph == PH_METALEN);
							final_blk = (vacc == '0);
							if (!final_blk)
								phase_d = PH_PAYLOAD;
							blk_emit = 1'b1;
							res_d.kind = meta ? KIND_META : KIND_SYSEX;
							res_d.first_value = meta ? hmt_e : 8'h00;
							res_d.payload_length = vacc;
						end
					end
					PH_PAYLOAD: begin
						br_d = br_e - 1'b1;
						final_blk = (br_d == '0);
						blk_emit = 1'b1;
						res_d.kind = KIND_PAYLOAD;
						res_d.first_value = b;
					end
					default: phase_d = PH_ERROR;
				endcase

				// Header or payload result, closing the event on its final byte
				if (blk_emit) begin
					res_v = 1'b1;
					res_d.status_byte = bcs;
					res_d.delta_ticks = hd_e;
					res_d.last = final_blk;
					if (final_blk) begin
						if (bcs == STATUS_META && hmt_d == META_END_OF_TRACK) begin
							res_d.end_of_track = 1'b1;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_DELTA;
							acc_d = '0;
							cnt_d = '0;
						end
					end
				end
			end
		end
	end

endmodule

[rtl/midi_track_event_parser.sv]
// Track event parser for a MIDI file: takes one byte of track event data per
// transaction and gives at most one result transaction per byte (channel event,
// SysEx or meta header, payload byte, or error). Bytes are taken one per clock
// cycle: the parser decides each byte combinationally, so throughput is one
// byte per cycle as long as results are taken. A four-entry byte queue
// separates the byte input from the parser, and a result register separates
// the parser from the result output, so either side may stall on its own. Each
// byte is registered in the queue, and its result in the result register.
module midi_track_event_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_ready,
	input  logic [7:0] data_byte,
	input  logic track_start,
	input  logic data_end,
	output logic event_valid,
	input  logic event_ready,
	output logic [2:0] kind,
	output logic [mtep_pkg::LEN_W-1:0] delta_ticks,
	output logic [7:0] status_byte,
	output logic [3:0] channel,
	output logic [7:0] first_value,
	output logic [7:0] second_value,
	output logic [mtep_pkg::LEN_W-1:0] payload_length,
	output logic last,
	output logic end_of_track,
	output logic [1:0] error_code
);
	import mtep_pkg::*;

	logic push;
	qent_t push_ent;
	logic queue_ready;
	logic q_valid;
	qent_t q_ent;
	logic q_pop;
	result_t res;

	// Accept and classify
	mtep_front u_front (
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.track_start(track_start),
		.data_end   (data_end),
		.push       (push),
		.push_ent   (push_ent),
		.queue_ready(queue_ready)
	);

	// Byte queue
	mtep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.push_ready(queue_ready),
		.pop_valid (q_valid),
		.pop_ent   (q_ent),
		.pop       (q_pop)
	);

	// Parser and result register
	mtep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ent    (q_ent),
		.q_pop    (q_pop),
		.res_valid(event_valid),
		.res_ready(event_ready),
		.res      (res)
	);

	// Result fields to ports
	assign kind = res.kind;
	assign delta_ticks = res.delta_ticks;
	assign status_byte = res.status_byte;
	assign channel = res.channel;
	assign first_value = res.first_value;
	assign second_value = res.second_value;
	assign payload_length = res.payload_length;
	assign last = res.last;
	assign end_of_track = res.end_of_track;
	assign error_code = res.error_code;

endmodule

[rtl/mtep_checker.sv]
`include "midi_track_event_parser_assert.svh"

module mtep_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_ready,
	input logic [7:0] data_byte,
	input logic track_start,
	input logic data_end,
	input logic event_valid,
	input logic event_ready,
	input logic [2:0] kind,
	input logic [mtep_pkg::LEN_W-1:0] delta_ticks,
	input logic [7:0] status_byte,
	input logic [3:0] channel,
	input logic [7:0] first_value,
	input logic [7:0] second_value,
	input logic [mtep_pkg::LEN_W-1:0] payload_length,
	input logic last,
	input logic end_of_track,
	input logic [1:0] error_code
);
	import mtep_pkg::*;

	// A stalled byte transaction holds
	`MTEP_ASSERT(a_byte_holds, byte_valid && !byte_ready |=> byte_valid && $stable(data_byte) && $stable(track_start) && $stable(data_end), "stalled byte changed")

	// A stalled result transaction holds
	`MTEP_ASSERT(a_result_holds, event_valid && !event_ready |=> event_valid && $stable(kind) && $stable(first_value) && $stable(delta_ticks) && $stable(status_byte) && $stable(payload_length) && $stable(last), "stalled result changed")

	// End of track closes a meta event
	`MTEP_ASSERT(a_eot_is_meta, event_valid && end_of_track |-> last && status_byte == STATUS_META, "end of track not on final meta result")

	// Channel fields only on channel events
	`MTEP_ASSERT(a_channel_fields, event_valid && kind != KIND_CHANNEL |-> channel == 4'd0 && second_value == 8'd0, "channel fields on non-channel result")

	// Error code only on errors and errors always close the event
	`MTEP_ASSERT(a_error_fields, event_valid |-> ((kind == KIND_ERROR) ? last : (error_code == ERR_TOO_LONG)), "bad error fields")

endmodule

bind midi_track_event_parser mtep_checker u_checker (.*);
